>>> hw/rtl/lirs_pkg.sv
// shared types and constants of the linear interpolation resampler
package lirs_pkg;

    // field and register widths
    localparam int SAMPLE_W   = 8;
    localparam int RATE_W     = 18;
    localparam int COUNT_W    = 24;
    localparam int TOTAL_W    = 31;
    localparam int PROD_W     = RATE_W + COUNT_W;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RATE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd2;

    // register reset values
    localparam logic [RATE_W-1:0]  RST_SOURCE_RATE  = 18'd6000;
    localparam logic [RATE_W-1:0]  RST_TARGET_RATE  = 18'd22050;
    localparam logic [COUNT_W-1:0] RST_SAMPLE_COUNT = 24'd2;

    // output count saturation
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 31'h7FFF_FFFF;

    // operation of the shared bit-serial unit
    typedef enum logic {
        OP_DIV,
        OP_MUL
    } t_unit_op;

    // request from the sequencer to the shared unit
    typedef struct packed {
        logic     start;
        t_unit_op op;
    } t_unit_req;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_STAGE,
        S_FINISH,
        S_SK_DIV,
        S_SK_DIV_W,
        S_SK_MUL,
        S_SK_MUL_W,
        S_D_MUL,
        S_D_DIV1,
        S_D_DIV1_W,
        S_D_DIV2,
        S_D_DIV2_W
    } t_state;

endpackage

>>> hw/rtl/lirs_shared_unit.sv
// shared bit-serial unit: restoring divide or shift-add multiply, one bit a cycle
module lirs_shared_unit
    import lirs_pkg::*;
#(
    parameter int UW = 42
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_unit_req     i_req,
    input  logic [UW-1:0] i_opa,
    input  logic [UW-1:0] i_opb,
    output logic          o_done,
    output logic [UW-1:0] o_result
);

    localparam int CW = $clog2(UW + 1);

    logic          r_busy;
    logic          r_done;
    t_unit_op      r_op;
    logic [CW-1:0] r_cnt;
    logic [UW:0]   r_acc;
    logic [UW-1:0] r_q;
    logic [UW-1:0] r_b;

    logic          w_div;
    logic [UW:0]   w_acc_sh;
    logic [UW+1:0] w_opb;
    logic [UW+1:0] w_sum;

    // one shared adder: subtract the divisor or add the multiplicand
    always_comb begin
        w_div    = (r_op == OP_DIV);
        w_acc_sh = {r_acc[UW-1:0], w_div ? r_q[UW-1] : 1'b0};
        if (w_div) begin
            w_opb = ~{2'b00, r_b};
        end else if (r_q[UW-1]) begin
            w_opb = {2'b00, r_b};
        end else begin
            w_opb = '0;
        end
        w_sum = {1'b0, w_acc_sh} + w_opb + {{(UW+1){1'b0}}, w_div};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(UW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_acc <= '0;
            r_q   <= i_opa;
            r_b   <= i_opb;
        end else if (r_busy) begin
            if (w_div) begin
                if (!w_sum[UW+1]) begin
                    r_acc <= w_sum[UW:0];
                    r_q   <= {r_q[UW-2:0], 1'b1};
                end else begin
                    r_acc <= w_acc_sh;
                    r_q   <= {r_q[UW-2:0], 1'b0};
                end
            end else begin
                r_acc <= w_sum[UW:0];
                r_q   <= {r_q[UW-2:0], 1'b0};
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = (r_op == OP_DIV) ? r_q : r_acc[UW-1:0];

endmodule

>>> hw/rtl/linear_interp_resampler.sv
// top level: linear interpolation sample rate converter for signed 8-bit blocks
// an item with k results runs check, multiply and stage for each result, then a last check and finish
// when outputs are dropped, a divide and a multiply on the shared unit skip past them
// a first sample of a block goes straight to finish; one item is in work at a time
// a register write, and reset, run a derive pass on the shared unit
// reset loads the default rates and count and then runs that pass before taking items
module linear_interp_resampler
    import lirs_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int MAX_OUTPUTS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [7:0]     i_sample_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [7:0]     o_sample_out,
    output logic                  o_run_last,
    output logic                  o_block_end
);

    localparam int F      = FRAC_BITS;
    localparam int STEP_W = COUNT_W + F;
    localparam int POS_W  = COUNT_W + F + 1;
    localparam int UW     = (POS_W > PROD_W) ? POS_W : PROD_W;
    localparam int SUM_W  = F + 10;
    localparam int CNT_W  = $clog2(MAX_OUTPUTS + 1);

    // state
    t_state                 r_state, n_state;
    logic [RATE_W-1:0]      r_src_rate, n_src_rate;
    logic [RATE_W-1:0]      r_tgt_rate, n_tgt_rate;
    logic [COUNT_W-1:0]     r_smp_cnt, n_smp_cnt;
    logic [SAMPLE_W-1:0]    r_prev, n_prev;
    logic [COUNT_W-1:0]     r_in_idx, n_in_idx;
    logic [TOTAL_W-1:0]     r_out_idx, n_out_idx;
    logic [POS_W-1:0]       r_pos, n_pos;
    logic [STEP_W-1:0]      r_step, n_step;
    logic [TOTAL_W-1:0]     r_total, n_total;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_pend_vld, n_pend_vld;
    logic                   r_out_vld, n_out_vld;

    // payload
    logic [SAMPLE_W-1:0]    r_cur, n_cur;
    logic [PROD_W-1:0]      r_prod, n_prod;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [SAMPLE_W-1:0]    r_pend_val, n_pend_val;
    logic [SAMPLE_W-1:0]    r_out_sample, n_out_sample;
    logic                   r_out_last, n_out_last;
    logic                   r_out_end, n_out_end;

    // shared unit connection
    t_unit_req              w_req;
    logic [UW-1:0]          w_opa;
    logic [UW-1:0]          w_opb;
    logic                   u_done;
    logic [UW-1:0]          u_result;

    // helpers
    logic                    w_out_free;
    logic                    w_in_range;
    logic                    w_more;
    logic                    w_cfg_ok;
    logic signed [8:0]       w_diff;
    logic signed [SUM_W-1:0] w_mprod;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [SUM_W-1:0] w_biased;
    logic signed [SUM_W-1:0] w_shift;
    logic [SAMPLE_W-1:0]     w_val;
    logic [TOTAL_W-1:0]      w_next;

    lirs_shared_unit #(
        .UW (UW)
    ) u_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_opa    (w_opa),
        .i_opb    (w_opb),
        .o_done   (u_done),
        .o_result (u_result)
    );

    // interpolation: prev*ONE + f*(cur-prev), then halve and scale back toward zero
    always_comb begin
        w_diff   = $signed({r_cur[7], r_cur}) - $signed({r_prev[7], r_prev});
        w_mprod  = $signed({1'b0, r_pos[F-1:0]}) * w_diff;
        w_sum    = w_mprod + $signed({{(SUM_W-SAMPLE_W-F){r_prev[7]}}, r_prev, {F{1'b0}}});
        w_biased = r_sum[SUM_W-1]
                 ? r_sum + $signed({{(SUM_W-F-1){1'b0}}, {(F+1){1'b1}}})
                 : r_sum;
        w_shift  = w_biased >>> (F + 1);
        w_val    = w_shift[SAMPLE_W-1:0];
    end

    // loop tests
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_in_range = (r_pos < POS_W'({r_in_idx, {F{1'b0}}})) && (r_out_idx < r_total);
    assign w_more     = w_in_range && (r_cnt < CNT_W'(MAX_OUTPUTS));
    assign w_cfg_ok   = (r_smp_cnt >= COUNT_W'(2)) && (r_src_rate != '0) && (r_tgt_rate != '0);
    assign w_next     = (u_result < UW'(r_total)) ? u_result[TOTAL_W-1:0] : r_total;

    // sequencer: next state, datapath updates and unit requests
    always_comb begin
        n_state      = r_state;
        n_src_rate   = r_src_rate;
        n_tgt_rate   = r_tgt_rate;
        n_smp_cnt    = r_smp_cnt;
        n_prev       = r_prev;
        n_in_idx     = r_in_idx;
        n_out_idx    = r_out_idx;
        n_pos        = r_pos;
        n_step       = r_step;
        n_total      = r_total;
        n_cnt        = r_cnt;
        n_pend_vld   = r_pend_vld;
        n_cur        = r_cur;
        n_prod       = r_prod;
        n_sum        = r_sum;
        n_pend_val   = r_pend_val;
        n_out_vld    = r_out_vld && i_out_stall;
        n_out_sample = r_out_sample;
        n_out_last   = r_out_last;
        n_out_end    = r_out_end;
        w_req.start  = 1'b0;
        w_req.op     = OP_DIV;
        w_opa        = '0;
        w_opb        = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cur   = i_sample_in;
                    n_cnt   = '0;
                    n_state = (r_in_idx != '0) ? S_CHECK : S_FINISH;
                end
            end
            S_CHECK: begin
                if (w_more) begin
                    n_state = S_MUL;
                end else if (w_in_range) begin
                    if (r_step != '0) begin
                        n_state = S_SK_DIV;
                    end else begin
                        n_out_idx = r_total;
                        n_pos     = '0;
                        n_state   = S_FINISH;
                    end
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_MUL: begin
                n_sum     = w_sum;
                n_out_idx = r_out_idx + 1'b1;
                n_pos     = r_pos + POS_W'(r_step);
                n_cnt     = r_cnt + 1'b1;
                n_state   = S_STAGE;
            end
            S_STAGE: begin
                if (!r_pend_vld || w_out_free) begin
                    if (r_pend_vld) begin
                        n_out_vld    = 1'b1;
                        n_out_sample = r_pend_val;
                        n_out_last   = 1'b0;
                        n_out_end    = 1'b0;
                    end
                    n_pend_val = w_val;
                    n_pend_vld = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_FINISH: begin
                if (!r_pend_vld || w_out_free) begin
                    if (r_pend_vld) begin
                        n_out_vld    = 1'b1;
                        n_out_sample = r_pend_val;
                        n_out_last   = 1'b1;
                        n_out_end    = (r_out_idx >= r_total);
                    end
                    n_pend_vld = 1'b0;
                    n_prev     = r_cur;
                    if (({1'b0, r_in_idx} + 1'b1) >= {1'b0, r_smp_cnt}) begin
                        n_in_idx  = '0;
                        n_out_idx = '0;
                        n_pos     = '0;
                    end else begin
                        n_in_idx = r_in_idx + 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_SK_DIV: begin
                w_req.start = 1'b1;
                w_req.op    = OP_DIV;
                w_opa       = UW'({r_in_idx, {F{1'b0}}}) + UW'(r_step) - UW'(1);
                w_opb       = UW'(r_step);
                n_state     = S_SK_DIV_W;
            end
            S_SK_DIV_W: begin
                if (u_done) begin
                    n_out_idx = w_next;
                    n_state   = S_SK_MUL;
                end
            end
            S_SK_MUL: begin
                w_req.start = 1'b1;
                w_req.op    = OP_MUL;
                w_opa       = UW'(r_out_idx);
                w_opb       = UW'(r_step);
                n_state     = S_SK_MUL_W;
            end
            S_SK_MUL_W: begin
                if (u_done) begin
                    n_pos   = u_result[POS_W-1:0];
                    n_state = S_FINISH;
                end
            end
            S_D_MUL: begin
                n_prod = r_smp_cnt * r_tgt_rate;
                if (w_cfg_ok) begin
                    n_state = S_D_DIV1;
                end else begin
                    n_total = '0;
                    n_step  = '0;
                    n_state = S_IDLE;
                end
            end
            S_D_DIV1: begin
                w_req.start = 1'b1;
                w_req.op    = OP_DIV;
                w_opa       = UW'(r_prod);
                w_opb       = UW'(r_src_rate);
                n_state     = S_D_DIV1_W;
            end
            S_D_DIV1_W: begin
                if (u_done) begin
                    if (u_result[UW-1:TOTAL_W] != '0) begin
                        n_total = TOTAL_MAX;
                        n_state = S_D_DIV2;
                    end else if (u_result[TOTAL_W-1:0] == '0) begin
                        n_total = '0;
                        n_step  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_total = u_result[TOTAL_W-1:0];
                        n_state = S_D_DIV2;
                    end
                end
            end
            S_D_DIV2: begin
                w_req.start = 1'b1;
                w_req.op    = OP_DIV;
                w_opa       = UW'({r_smp_cnt - 1'b1, {F{1'b0}}});
                w_opb       = UW'(r_total);
                n_state     = S_D_DIV2_W;
            end
            S_D_DIV2_W: begin
                if (u_done) begin
                    n_step  = u_result[STEP_W-1:0];
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // register write restarts the block and the derive pass
        if (i_cfg_we && (i_cfg_index <= CFG_SAMPLE_COUNT)) begin
            unique case (i_cfg_index)
                CFG_SOURCE_RATE:  n_src_rate = i_cfg_data[RATE_W-1:0];
                CFG_TARGET_RATE:  n_tgt_rate = i_cfg_data[RATE_W-1:0];
                CFG_SAMPLE_COUNT: n_smp_cnt  = i_cfg_data[COUNT_W-1:0];
                default:          n_smp_cnt  = r_smp_cnt;
            endcase
            n_in_idx  = '0;
            n_out_idx = '0;
            n_pos     = '0;
            n_state   = S_D_MUL;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_D_MUL;
            r_src_rate <= RST_SOURCE_RATE;
            r_tgt_rate <= RST_TARGET_RATE;
            r_smp_cnt  <= RST_SAMPLE_COUNT;
            r_prev     <= '0;
            r_in_idx   <= '0;
            r_out_idx  <= '0;
            r_pos      <= '0;
            r_step     <= '0;
            r_total    <= '0;
            r_cnt      <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_src_rate <= n_src_rate;
            r_tgt_rate <= n_tgt_rate;
            r_smp_cnt  <= n_smp_cnt;
            r_prev     <= n_prev;
            r_in_idx   <= n_in_idx;
            r_out_idx  <= n_out_idx;
            r_pos      <= n_pos;
            r_step     <= n_step;
            r_total    <= n_total;
            r_cnt      <= n_cnt;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_prod       <= n_prod;
        r_sum        <= n_sum;
        r_pend_val   <= n_pend_val;
        r_out_sample <= n_out_sample;
        r_out_last   <= n_out_last;
        r_out_end    <= n_out_end;
    end

    // ports
    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_vld;
    assign o_sample_out = r_out_sample;
    assign o_run_last   = r_out_last;
    assign o_block_end  = r_out_end;

    // checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_OUTPUTS))
        else $error("result count per transfer above limit");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_idx <= r_total)
        else $error("output index beyond output total");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_block_end) |-> o_run_last)
        else $error("block end without run last");

    a_push_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == S_STAGE || $past(r_state) == S_FINISH))
        else $error("output loaded outside stage or finish");

    a_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> o_in_stall)
        else $error("input open while a result is pending");

endmodule
